FILE: rtl/bckv_pkg.sv
// Shared types and constants for the boot configuration key/value parser.
// Holds the phase encoding, result kinds, the result record and key lookups.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bckv_pkg;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_LINE  = 4'b0001,
    PH_KEY   = 4'b0010,
    PH_SKIP  = 4'b0100,
    PH_VALUE = 4'b1000
  } phase_e;

  // Kind of result beat.
  typedef enum logic [1:0] {
    KIND_VERSION  = 2'd0,
    KIND_PATH     = 2'd1,
    KIND_PATH_END = 2'd2,
    KIND_BUF_END  = 2'd3
  } kind_e;

  // Special characters.
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_EQ    = 8'h3D;
  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;

  // Key lengths of the two recognized keys.
  localparam int unsigned VersionLen = 7;
  localparam int unsigned KernelLen  = 6;

  // One result record as it leaves the parser.
  typedef struct packed {
    kind_e       kind;
    logic [31:0] version;
    logic [7:0]  pbyte;
    logic [5:0]  pidx;
    logic [5:0]  plen;
    logic        trunc;
    logic        eob;
  } result_t;

  // Character of "version" at a given position (position below seven).
  function automatic logic [7:0] version_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h76; // v
      3'd1:    ch = 8'h65; // e
      3'd2:    ch = 8'h72; // r
      3'd3:    ch = 8'h73; // s
      3'd4:    ch = 8'h69; // i
      3'd5:    ch = 8'h6F; // o
      3'd6:    ch = 8'h6E; // n
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Character of "kernel" at a given position (position below six).
  function automatic logic [7:0] kernel_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h6B; // k
      3'd1:    ch = 8'h65; // e
      3'd2:    ch = 8'h72; // r
      3'd3:    ch = 8'h6E; // n
      3'd4:    ch = 8'h65; // e
      3'd5:    ch = 8'h6C; // l
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bckv_parse.sv
// Parser state and per-byte next-state logic of the key/value parser.
// Produces at most one result record per byte. Depends on bckv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bckv_parse #(
  parameter int unsigned KEY_BYTES   = 32,
  parameter int unsigned VALUE_BYTES = 128,
  parameter int unsigned PATH_BYTES  = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       text_byte_i,
  output logic                  res_valid_o,
  output bckv_pkg::result_t     res_o
);

  localparam int unsigned KeyW  = $clog2(KEY_BYTES);
  localparam int unsigned ValW  = $clog2(VALUE_BYTES);
  localparam int unsigned PathW = $clog2(PATH_BYTES);

  localparam logic [KeyW-1:0]  KeyMax  = KeyW'(KEY_BYTES - 1);
  localparam logic [ValW-1:0]  ValMax  = ValW'(VALUE_BYTES - 1);
  localparam logic [PathW-1:0] PathMax = PathW'(PATH_BYTES - 1);
  localparam logic [KeyW-1:0]  VerLen  = KeyW'(bckv_pkg::VersionLen);
  localparam logic [KeyW-1:0]  KerLen  = KeyW'(bckv_pkg::KernelLen);

  bckv_pkg::phase_e phase_q, phase_d;
  logic [KeyW-1:0]  key_cnt_q, key_cnt_d;
  logic [ValW-1:0]  val_cnt_q, val_cnt_d;
  logic             ver_match_q, ver_match_d;
  logic             ker_match_q, ker_match_d;
  logic [31:0]      acc_q, acc_d;
  logic             stopped_q, stopped_d;
  logic [PathW-1:0] path_cnt_q, path_cnt_d;
  logic             path_ovf_q, path_ovf_d;

  // Key stepping works on either the held key state or a fresh key.
  logic [KeyW-1:0]  kc;
  logic             kvm;
  logic             kkm;
  logic             do_key;
  logic             closing;
  logic             kept;
  logic [31:0]      acc_step;

  assign acc_step = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0}
                    + {24'd0, text_byte_i} - {24'd0, bckv_pkg::CHR_ZERO};

  // Next state and result for the current byte.
  always_comb begin
    phase_d     = phase_q;
    key_cnt_d   = key_cnt_q;
    val_cnt_d   = val_cnt_q;
    ver_match_d = ver_match_q;
    ker_match_d = ker_match_q;
    acc_d       = acc_q;
    stopped_d   = stopped_q;
    path_cnt_d  = path_cnt_q;
    path_ovf_d  = path_ovf_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    kc          = key_cnt_q;
    kvm         = ver_match_q;
    kkm         = ker_match_q;
    do_key      = 1'b0;
    closing     = 1'b0;
    kept        = 1'b0;

    if (text_byte_i == bckv_pkg::CHR_NUL) begin
      // Terminating zero closes any open value and returns to reset state.
      res_valid_o = 1'b1;
      res_o.eob   = 1'b1;
      if (phase_q == bckv_pkg::PH_VALUE && ver_match_q) begin
        res_o.kind    = bckv_pkg::KIND_VERSION;
        res_o.version = acc_q;
      end else if (phase_q == bckv_pkg::PH_VALUE && ker_match_q) begin
        res_o.kind  = bckv_pkg::KIND_PATH_END;
        res_o.plen  = 6'(path_cnt_q);
        res_o.trunc = path_ovf_q;
      end else begin
        res_o.kind = bckv_pkg::KIND_BUF_END;
      end
      phase_d     = bckv_pkg::PH_LINE;
      key_cnt_d   = '0;
      val_cnt_d   = '0;
      ver_match_d = 1'b1;
      ker_match_d = 1'b1;
      acc_d       = '0;
      stopped_d   = 1'b0;
      path_cnt_d  = '0;
      path_ovf_d  = 1'b0;
    end else begin
      unique case (phase_q)
        bckv_pkg::PH_LINE: begin
          if (text_byte_i != bckv_pkg::CHR_LF) begin
            // A new key begins; a leading colon is skipped.
            kc          = '0;
            kvm         = 1'b1;
            kkm         = 1'b1;
            key_cnt_d   = '0;
            ver_match_d = 1'b1;
            ker_match_d = 1'b1;
            if (text_byte_i == bckv_pkg::CHR_COLON) begin
              phase_d = bckv_pkg::PH_KEY;
            end else begin
              do_key = 1'b1;
            end
          end
        end
        bckv_pkg::PH_KEY: begin
          do_key = 1'b1;
        end
        bckv_pkg::PH_SKIP: begin
          if (text_byte_i == bckv_pkg::CHR_LF) begin
            phase_d = bckv_pkg::PH_LINE;
          end
        end
        bckv_pkg::PH_VALUE: begin
          if (text_byte_i == bckv_pkg::CHR_LF) begin
            // Newline ends the value.
            phase_d = bckv_pkg::PH_LINE;
            if (ver_match_q) begin
              res_valid_o   = 1'b1;
              res_o.kind    = bckv_pkg::KIND_VERSION;
              res_o.version = acc_q;
            end else if (ker_match_q) begin
              res_valid_o = 1'b1;
              res_o.kind  = bckv_pkg::KIND_PATH_END;
              res_o.plen  = 6'(path_cnt_q);
              res_o.trunc = path_ovf_q;
            end
          end else begin
            val_cnt_d = val_cnt_q + 1'b1;
            closing   = (val_cnt_d >= ValMax);
            if (closing) begin
              phase_d = bckv_pkg::PH_LINE;
            end
            if (ver_match_q) begin
              // Decimal accumulation until a carriage return.
              if (!stopped_q) begin
                if (text_byte_i == bckv_pkg::CHR_CR) begin
                  stopped_d = 1'b1;
                end else begin
                  acc_d = acc_step;
                end
              end
              if (closing) begin
                res_valid_o   = 1'b1;
                res_o.kind    = bckv_pkg::KIND_VERSION;
                res_o.version = acc_d;
              end
            end else if (ker_match_q) begin
              // Path bytes are kept while fewer than PATH_BYTES - 1 are held.
              kept = (path_cnt_q < PathMax);
              if (kept) begin
                path_cnt_d = path_cnt_q + 1'b1;
              end else begin
                path_ovf_d = 1'b1;
              end
              if (closing) begin
                res_valid_o = 1'b1;
                res_o.kind  = bckv_pkg::KIND_PATH_END;
                res_o.pbyte = kept ? text_byte_i : 8'd0;
                res_o.pidx  = kept ? 6'(path_cnt_q) : 6'd0;
                res_o.plen  = 6'(path_cnt_d);
                res_o.trunc = path_ovf_d;
              end else if (kept) begin
                res_valid_o = 1'b1;
                res_o.kind  = bckv_pkg::KIND_PATH;
                res_o.pbyte = text_byte_i;
                res_o.pidx  = 6'(path_cnt_q);
              end
            end
          end
        end
        default: begin
          phase_d = bckv_pkg::PH_LINE;
        end
      endcase

      // One key byte: equals sign, newline, a key character or overflow.
      if (do_key) begin
        if (text_byte_i == bckv_pkg::CHR_EQ) begin
          ver_match_d = kvm && (kc == VerLen);
          ker_match_d = kkm && (kc == KerLen);
          val_cnt_d   = '0;
          acc_d       = '0;
          stopped_d   = 1'b0;
          path_cnt_d  = '0;
          path_ovf_d  = 1'b0;
          phase_d     = bckv_pkg::PH_VALUE;
        end else if (text_byte_i == bckv_pkg::CHR_LF) begin
          phase_d = bckv_pkg::PH_LINE;
        end else if (kc < KeyMax) begin
          ver_match_d = kvm && (kc < VerLen)
                        && (text_byte_i == bckv_pkg::version_char(kc[2:0]));
          ker_match_d = kkm && (kc < KerLen)
                        && (text_byte_i == bckv_pkg::kernel_char(kc[2:0]));
          key_cnt_d   = kc + 1'b1;
          phase_d     = bckv_pkg::PH_KEY;
        end else begin
          phase_d = bckv_pkg::PH_SKIP;
        end
      end
    end
  end

  // State registers advance only on an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= bckv_pkg::PH_LINE;
      key_cnt_q   <= '0;
      val_cnt_q   <= '0;
      ver_match_q <= 1'b1;
      ker_match_q <= 1'b1;
      acc_q       <= '0;
      stopped_q   <= 1'b0;
      path_cnt_q  <= '0;
      path_ovf_q  <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      key_cnt_q   <= key_cnt_d;
      val_cnt_q   <= val_cnt_d;
      ver_match_q <= ver_match_d;
      ker_match_q <= ker_match_d;
      acc_q       <= acc_d;
      stopped_q   <= stopped_d;
      path_cnt_q  <= path_cnt_d;
      path_ovf_q  <= path_ovf_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/boot_config_key_value_parser.sv
// Boot configuration key/value parser, top level.
// A result is registered; it appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the output stalls; it refills as it drains.
// Reset: asynchronous, active low; parser returns to line start, output empties.
// Uses bckv_pkg and bckv_parse.
`timescale 1ns / 1ps
`default_nettype none

module boot_config_key_value_parser #(
  parameter int unsigned KEY_BYTES   = 32,
  parameter int unsigned VALUE_BYTES = 128,
  parameter int unsigned PATH_BYTES  = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         text_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              result_kind_o,
  output logic signed [31:0]      version_value_o,
  output logic [7:0]              path_byte_o,
  output logic [5:0]              path_index_o,
  output logic [5:0]              path_length_o,
  output logic                    path_truncated_o,
  output logic                    end_of_buffer_o
);

  logic              accept;
  logic              res_valid;
  bckv_pkg::result_t res;
  bckv_pkg::result_t res_q;
  logic              out_valid_q, out_valid_d;

  // A new beat is taken whenever the output register is empty or draining.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  bckv_parse #(
    .KEY_BYTES  (KEY_BYTES),
    .VALUE_BYTES(VALUE_BYTES),
    .PATH_BYTES (PATH_BYTES)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (accept),
    .text_byte_i(text_byte_i),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Output valid flag.
  always_comb begin
    if (accept) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = res_q.kind;
  assign version_value_o  = res_q.version;
  assign path_byte_o      = res_q.pbyte;
  assign path_index_o     = res_q.pidx;
  assign path_length_o    = res_q.plen;
  assign path_truncated_o = res_q.trunc;
  assign end_of_buffer_o  = res_q.eob;

endmodule

`default_nettype wire
